[src/bgryuv_pkg.sv]
`default_nettype none

package bgryuv_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned ADDR_W     = 25;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned STRIDE_W   = 14;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  // wide enough for any clamped size up to the largest frame dimension
  localparam int unsigned DIM_W      = 15;
  // colour sums, kept non-negative by the bias so modular arithmetic is exact
  localparam int unsigned SUM_W      = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_PIXELS  = 3'd0,
    REG_FRAME_ROWS  = 3'd1,
    REG_LUMA_STRIDE = 3'd2,
    REG_U_STRIDE    = 3'd3,
    REG_V_STRIDE    = 3'd4
  } cfg_reg_t;

  localparam logic [SIZE_W-1:0]   RST_ROW_PIXELS  = 13'd640;
  localparam logic [SIZE_W-1:0]   RST_FRAME_ROWS  = 13'd480;
  localparam logic [STRIDE_W-1:0] RST_LUMA_STRIDE = 14'd640;
  localparam logic [STRIDE_W-1:0] RST_U_STRIDE    = 14'd320;
  localparam logic [STRIDE_W-1:0] RST_V_STRIDE    = 14'd320;

  // BT.601 integer coefficients (magnitudes; signs applied in the datapath)
  localparam logic [SUM_W-1:0] Y_R  = 18'd66;
  localparam logic [SUM_W-1:0] Y_G  = 18'd129;
  localparam logic [SUM_W-1:0] Y_B  = 18'd25;
  localparam logic [SUM_W-1:0] U_R  = 18'd38;
  localparam logic [SUM_W-1:0] U_G  = 18'd74;
  localparam logic [SUM_W-1:0] U_B  = 18'd112;
  localparam logic [SUM_W-1:0] V_R  = 18'd112;
  localparam logic [SUM_W-1:0] V_G  = 18'd94;
  localparam logic [SUM_W-1:0] V_B  = 18'd18;
  localparam logic [SUM_W-1:0] ROUND       = 18'd128;
  localparam logic [SUM_W-1:0] CHROMA_BIAS = 18'd32896;  // rounding plus 128 << 8
  localparam logic [PIX_W-1:0] LUMA_OFFSET = 8'd16;

  typedef enum logic {
    PLANE_U = 1'b0,
    PLANE_V = 1'b1
  } plane_t;

endpackage

`default_nettype wire

[src/bgr_to_yuv420_planar_writer_unit.sv]
`default_nettype none

// channel  | handshake            | payload
// ---------+----------------------+------------------------------
// pixel in | in_valid / in_ready  | blue, green, red
// result   | out_valid / out_ready| luma_*, chroma_*, frame_end
// config   | cfg_wr_en            | cfg_index, cfg_data
//
// One pixel per clock sustained while out_ready stays high; each accepted transfer
// passes through the input register, then the result register.
// Raster counters advance at input acceptance; strides are read in stage two.
// A stalled result register holds stage one, which in turn drops in_ready.
// Synchronous reset clears valids, counters and loads the default frame setup.
module bgr_to_yuv420_planar_writer_unit #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bgryuv_pkg::PIX_W-1:0]      blue,
  input  logic [bgryuv_pkg::PIX_W-1:0]      green,
  input  logic [bgryuv_pkg::PIX_W-1:0]      red,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bgryuv_pkg::PIX_W-1:0]      luma_value,
  output logic [bgryuv_pkg::ADDR_W-1:0]     luma_address,
  output logic                              chroma_write,
  output logic                              chroma_plane,
  output logic [bgryuv_pkg::PIX_W-1:0]      chroma_value,
  output logic [bgryuv_pkg::ADDR_W-1:0]     chroma_address,
  output logic                              frame_end,
  input  logic                              cfg_wr_en,
  input  logic [bgryuv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bgryuv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bgryuv_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);

  logic [SIZE_W-1:0]   row_pixels;
  logic [SIZE_W-1:0]   frame_rows;
  logic [STRIDE_W-1:0] luma_stride;
  logic [STRIDE_W-1:0] u_stride;
  logic [STRIDE_W-1:0] v_stride;

  logic [COL_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_blue, s1_green, s1_red;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_last;

  logic in_xfer, s1_adv;

  logic [DIM_W-1:0] width_eff, height_eff;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic             col_wrap, row_wrap;

  logic [SUM_W-1:0]    b_ext, g_ext, r_ext;
  logic [SUM_W-1:0]    y_sum, u_sum, v_sum;
  logic [PIX_W-1:0]    y_val, c_val;
  logic [STRIDE_W-1:0] c_stride;
  logic [ADDR_W-1:0]   l_addr, c_addr;
  logic                even_col;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pixels  <= RST_ROW_PIXELS;
      frame_rows  <= RST_FRAME_ROWS;
      luma_stride <= RST_LUMA_STRIDE;
      u_stride    <= RST_U_STRIDE;
      v_stride    <= RST_V_STRIDE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROW_PIXELS:  row_pixels  <= cfg_data[SIZE_W-1:0];
        REG_FRAME_ROWS:  frame_rows  <= cfg_data[SIZE_W-1:0];
        REG_LUMA_STRIDE: luma_stride <= cfg_data[STRIDE_W-1:0];
        REG_U_STRIDE:    u_stride    <= cfg_data[STRIDE_W-1:0];
        REG_V_STRIDE:    v_stride    <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  // raster position
  always_comb begin
    if (row_pixels == '0) begin
      width_eff = DIM_W'(1);
    end else if (DIM_W'(row_pixels) > DIM_W'(MAX_WIDTH)) begin
      width_eff = DIM_W'(MAX_WIDTH);
    end else begin
      width_eff = DIM_W'(row_pixels);
    end
    if (frame_rows == '0) begin
      height_eff = DIM_W'(1);
    end else if (DIM_W'(frame_rows) > DIM_W'(MAX_HEIGHT)) begin
      height_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      height_eff = DIM_W'(frame_rows);
    end
    col_inc  = DIM_W'(column_count) + DIM_W'(1);
    row_inc  = DIM_W'(row_count) + DIM_W'(1);
    col_wrap = col_inc >= width_eff;
    row_wrap = row_inc >= height_eff;
    column_count_next = col_wrap ? '0 : col_inc[COL_W-1:0];
    if (!col_wrap) begin
      row_count_next = row_count;
    end else begin
      row_count_next = row_wrap ? '0 : row_inc[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_xfer) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_blue  <= blue;
      s1_green <= green;
      s1_red   <= red;
      s1_col   <= column_count;
      s1_row   <= row_count;
      s1_last  <= col_wrap && row_wrap;
    end
  end

  // colour conversion and addressing
  always_comb begin
    b_ext = SUM_W'(s1_blue);
    g_ext = SUM_W'(s1_green);
    r_ext = SUM_W'(s1_red);
    y_sum = Y_R * r_ext + Y_G * g_ext + Y_B * b_ext + ROUND;
    u_sum = U_B * b_ext - U_R * r_ext - U_G * g_ext + CHROMA_BIAS;
    v_sum = V_R * r_ext - V_G * g_ext - V_B * b_ext + CHROMA_BIAS;
    y_val = y_sum[15:8] + LUMA_OFFSET;
    c_val = s1_row[0] ? v_sum[15:8] : u_sum[15:8];
    c_stride = s1_row[0] ? v_stride : u_stride;
    even_col = !s1_col[0];
    l_addr = ADDR_W'(s1_row) * ADDR_W'(luma_stride) + ADDR_W'(s1_col);
    c_addr = ADDR_W'(s1_row >> 1) * ADDR_W'(c_stride) + ADDR_W'(s1_col >> 1);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      luma_value     <= y_val;
      luma_address   <= l_addr;
      chroma_write   <= even_col;
      chroma_plane   <= even_col && s1_row[0] ? PLANE_V : PLANE_U;
      chroma_value   <= even_col ? c_val : '0;
      chroma_address <= even_col ? c_addr : '0;
      frame_end      <= s1_last;
    end
  end

  // checks
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    in_xfer && col_wrap && row_wrap |=> column_count == '0 && row_count == '0)
    else $error("counters did not wrap at frame end");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |=> s1_valid)
    else $error("stage one dropped while result stalled");

  a_odd_col: assert property (@(posedge clk) disable iff (rst)
    out_valid && !chroma_write |-> chroma_value == '0 && chroma_address == '0
      && chroma_plane == PLANE_U)
    else $error("chroma fields set on odd column");

endmodule

`default_nettype wire
